/* design/assert_macros.svh */
// assertion helpers for the checking files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define WSD_CHECK(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define WSD_CHECK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define WSD_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/wsd_pkg.sv */
package wsd_pkg;

   // fixed field widths
   localparam int ID_W     = 16;
   localparam int OP_W     = 3;
   localparam int LIMIT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int STEAL_W  = 7;
   localparam int LEFT_W   = 8;
   localparam int TOTAL_W  = 32;

   typedef logic [OP_W-1:0]     opcode_type;
   typedef logic [ID_W-1:0]     id_type;
   typedef logic [LIMIT_W-1:0]  limit_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [STEAL_W-1:0]  steal_type;
   typedef logic [LEFT_W-1:0]   left_type;
   typedef logic [TOTAL_W-1:0]  total_type;

   // operation codes
   localparam opcode_type OP_PUSH       = 3'd0;
   localparam opcode_type OP_POP        = 3'd1;
   localparam opcode_type OP_POP_CHILD  = 3'd2;
   localparam opcode_type OP_STEAL_ONE  = 3'd3;
   localparam opcode_type OP_STEAL_MANY = 3'd4;
   localparam opcode_type OP_STEAL_HALF = 3'd5;

   // result status codes
   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_EMPTY     = 2'd1;
   localparam status_type STAT_NOT_CHILD = 2'd2;
   localparam status_type STAT_FULL      = 2'd3;

endpackage

/* design/wsd_ifs.sv */
// request channel
interface wsd_req_if import wsd_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   id_type     task_id;
   id_type     parent_id;
   limit_type  steal_limit;

   modport source (output valid, output opcode, output task_id, output parent_id,
                   output steal_limit, input ready);
   modport sink   (input valid, input opcode, input task_id, input parent_id,
                   input steal_limit, output ready);
endinterface

// response channel
interface wsd_rsp_if import wsd_pkg::*; ();
   logic       valid;
   logic       ready;
   id_type     out_task;
   status_type status;
   logic       is_last;
   steal_type  steal_count;
   left_type   tasks_left;
   total_type  steals_so_far;

   modport source (output valid, output out_task, output status, output is_last,
                   output steal_count, output tasks_left, output steals_so_far,
                   input ready);
   modport sink   (input valid, input out_task, input status, input is_last,
                   input steal_count, input tasks_left, input steals_so_far,
                   output ready);
endinterface

/* design/wsd_ring_add.sv */
module wsd_ring_add #(
   parameter int DEPTH = 128
) (
   input  logic [$clog2(DEPTH)-1:0] base,
   input  logic [$clog2(DEPTH)-1:0] offset,
   output logic [$clog2(DEPTH)-1:0] pos
);
   localparam int AW = $clog2(DEPTH);

   logic [AW:0] raw_sum;

   // modular add, both operands below depth
   always_comb begin
      raw_sum = {1'b0, base} + {1'b0, offset};
      if (raw_sum >= (AW+1)'(DEPTH)) begin
         pos = AW'(raw_sum - (AW+1)'(DEPTH));
      end else begin
         pos = AW'(raw_sum);
      end
   end
endmodule

/* design/wsd_steal_size.sv */
module wsd_steal_size import wsd_pkg::*; #(
   parameter int DEPTH     = 128,
   parameter int MAX_STEAL = 64
) (
   input  logic [$clog2(DEPTH+1)-1:0] count,
   input  logic                       is_many,
   input  limit_type                  limit,
   output steal_type                  size
);
   localparam int CW = $clog2(DEPTH+1);
   localparam int NW = (CW > STEAL_W) ? CW : STEAL_W;

   logic [NW-1:0] half;
   logic [NW-1:0] lim_eff;
   logic [NW-1:0] n_val;

   // half the count, at least one, capped by limit (zero taken as one) for steal many, and by max
   always_comb begin
      half    = NW'(count >> 1);
      lim_eff = (limit == '0) ? NW'(1) : NW'(limit);
      n_val   = (half == '0) ? NW'(1) : half;
      if (is_many && (n_val > lim_eff)) begin
         n_val = lim_eff;
      end
      if (n_val > NW'(MAX_STEAL)) begin
         n_val = NW'(MAX_STEAL);
      end
      size = STEAL_W'(n_val);
   end
endmodule

/* design/wsd_slot_mem.sv */
module wsd_slot_mem #(
   parameter int DEPTH   = 128,
   parameter int ID_BITS = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [ID_BITS-1:0]       wr_task,
   input  logic [ID_BITS-1:0]       wr_parent,
   output logic [ID_BITS-1:0]       rd_task,
   output logic [ID_BITS-1:0]       rd_parent
);
   logic [2*ID_BITS-1:0] slots [DEPTH];

   // single address port: one write, one registered read or both a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots[addr] <= {wr_parent, wr_task};
      end
      if (rd_en) begin
         {rd_parent, rd_task} <= slots[addr];
      end
   end
endmodule

/* design/work_stealing_deque_core.sv */
// Bounded work-stealing deque of task ids with parent ids, kept in a ring of DEPTH slots.
// One request is taken at a time. Push, refused and empty requests give their single result
// item in the cycle after the request is taken. Pop, pop child and steal one read the slot
// memory first, then load the result from its registered read data. A steal run of n tasks
// gives one result item a cycle while the response channel is free, newest stolen first and
// the oldest last with is_last set. The single-port slot memory with its registered read data
// and response stalls set the pace. No clearing pass follows reset; the deque starts empty.
`include "assert_macros.svh"

module work_stealing_deque_core import wsd_pkg::*; #(
   parameter int DEPTH     = 128,
   parameter int ID_BITS   = 16,
   parameter int MAX_STEAL = 64
) (
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_ch,
   wsd_rsp_if.source rsp_ch
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   // sequencer states
   localparam logic SQ_IDLE = 1'b0;
   localparam logic SQ_RUN  = 1'b1;

   // kind of read in flight
   localparam logic [1:0] K_POP   = 2'd0;
   localparam logic [1:0] K_CHILD = 2'd1;
   localparam logic [1:0] K_STEAL = 2'd2;

   logic               state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [AW-1:0]      oldest_ff, oldest_in;
   logic [CW-1:0]      count_ff, count_in;
   total_type          total_ff, total_in;
   logic [ID_BITS-1:0] query_ff, query_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   steal_type          run_left_ff, run_left_in;
   steal_type          run_n_ff, run_n_in;

   logic       rsp_valid_ff, rsp_valid_in;
   id_type     rsp_task_ff, rsp_task_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;
   steal_type  rsp_count_ff, rsp_count_in;
   left_type   rsp_left_ff, rsp_left_in;
   total_type  rsp_total_ff, rsp_total_in;

   logic               out_free;
   logic               req_ready;
   logic               req_fire;
   logic               rsp_load;
   logic [AW-1:0]      ring_a, ring_b, ring_out;
   logic [AW-1:0]      oldest_adv;
   steal_type          size_n;
   steal_type          steal_n;
   logic               mem_we, mem_re;
   logic [ID_BITS-1:0] rd_task, rd_parent;

   // handshake
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready    = (state_ff == SQ_IDLE) && out_free;
   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;

   // steal run length
   wsd_steal_size #(
      .DEPTH     (DEPTH),
      .MAX_STEAL (MAX_STEAL)
   ) u_size (
      .count   (count_ff),
      .is_many (req_ch.opcode == OP_STEAL_MANY),
      .limit   (req_ch.steal_limit),
      .size    (size_n)
   );

   assign steal_n = (req_ch.opcode == OP_STEAL_ONE) ? STEAL_W'(1) : size_n;

   // shared ring adder operands
   always_comb begin
      ring_a = oldest_ff;
      ring_b = '0;
      if (state_ff == SQ_RUN) begin
         ring_a = rd_addr_ff;
         ring_b = AW'(DEPTH - 1);
      end else begin
         case (req_ch.opcode) inside
            OP_PUSH:              ring_b = AW'(count_ff);
            OP_POP, OP_POP_CHILD: ring_b = AW'(count_ff - CW'(1));
            default:              ring_b = AW'(steal_n - STEAL_W'(1));
         endcase
      end
   end

   wsd_ring_add #(
      .DEPTH (DEPTH)
   ) u_ring (
      .base   (ring_a),
      .offset (ring_b),
      .pos    (ring_out)
   );

   // oldest moves one past the first slot read by a steal
   assign oldest_adv = (ring_out == AW'(DEPTH - 1)) ? '0 : ring_out + AW'(1);

   wsd_slot_mem #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .rd_en     (mem_re),
      .addr      (ring_out),
      .wr_task   (ID_BITS'(req_ch.task_id)),
      .wr_parent (ID_BITS'(req_ch.parent_id)),
      .rd_task   (rd_task),
      .rd_parent (rd_parent)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      query_in      = query_ff;
      rd_addr_in    = rd_addr_ff;
      run_left_in   = run_left_ff;
      run_n_in      = run_n_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_total_in  = rsp_total_ff;

      unique case (state_ff)
         SQ_IDLE: begin
            if (req_fire) begin
               query_in      = ID_BITS'(req_ch.parent_id);
               rsp_task_in   = '0;
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b1;
               rsp_count_in  = '0;
               unique case (req_ch.opcode) inside
                  OP_PUSH: begin
                     rsp_load = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP, OP_POP_CHILD: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = SQ_RUN;
                        if (req_ch.opcode == OP_POP) begin
                           kind_in  = K_POP;
                           count_in = count_ff - CW'(1);
                        end else begin
                           kind_in = K_CHILD;
                        end
                     end
                  end
                  OP_STEAL_ONE, OP_STEAL_MANY, OP_STEAL_HALF: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_re      = 1'b1;
                        state_in    = SQ_RUN;
                        kind_in     = K_STEAL;
                        rd_addr_in  = ring_out;
                        oldest_in   = oldest_adv;
                        count_in    = count_ff - CW'(steal_n);
                        total_in    = total_ff + TOTAL_W'(1);
                        run_left_in = steal_n;
                        run_n_in    = steal_n;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         SQ_RUN: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_task_in   = ID_W'(rd_task);
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b1;
               rsp_count_in  = '0;
               unique case (kind_ff)
                  K_CHILD: begin
                     state_in = SQ_IDLE;
                     if (rd_parent == query_ff) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        rsp_task_in   = '0;
                        rsp_status_in = STAT_NOT_CHILD;
                     end
                  end
                  K_STEAL: begin
                     rsp_count_in = run_n_ff;
                     if (run_left_ff == STEAL_W'(1)) begin
                        state_in = SQ_IDLE;
                     end else begin
                        rsp_last_in = 1'b0;
                        mem_re      = 1'b1;
                        rd_addr_in  = ring_out;
                        run_left_in = run_left_ff - STEAL_W'(1);
                     end
                  end
                  default: begin
                     state_in = SQ_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase

      // counters shown after the operation
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = LEFT_W'(count_in);
         rsp_total_in = total_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= K_POP;
         run_left_ff  <= '0;
         run_n_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         run_left_ff  <= run_left_in;
         run_n_ff     <= run_n_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // response outputs
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_task      = rsp_task_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.is_last       = rsp_last_ff;
   assign rsp_ch.steal_count   = rsp_count_ff;
   assign rsp_ch.tasks_left    = rsp_left_ff;
   assign rsp_ch.steals_so_far = rsp_total_ff;

   // checks
   `WSD_CHECK(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "task count above depth")
   `WSD_CHECK_IMPL(a_run_left, clock, reset, (state_ff == SQ_RUN) && (kind_ff == K_STEAL), (run_left_ff != '0) && (run_left_ff <= run_n_ff), "steal run counter out of range")
   `WSD_CHECK_IMPL(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ch.ready, !rsp_load, "result loaded over a waiting item")
   `WSD_CHECK_NEXT(a_total_step, clock, reset, 1'b1, (total_ff == $past(total_ff)) || (total_ff == $past(total_ff) + TOTAL_W'(1)), "steal total jumped")

endmodule
